// ===== rtl/button_single_double_click_detector_top_assert.svh =====
// Assertion macros for the click detector checker
`ifndef BUTTON_SINGLE_DOUBLE_CLICK_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_SINGLE_DOUBLE_CLICK_DETECTOR_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted
`define BSDC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also runs through reset
`define BSDC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/bsdc_pkg.sv =====
// Shared types and constants of the click detector
`timescale 1ns / 1ps

package bsdc_pkg;

	localparam int CFG_W = 24;
	localparam int IVL_W = 24;
	localparam int CNT_W = 2;

	// register indexes on the configuration port
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_DOUBLE   = 1'b1;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 24'd10000;
	localparam logic [CFG_W-1:0] DOUBLE_RST   = 24'd1000000;

	localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
	localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
	localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

	typedef struct packed {
		logic             single_click;
		logic             double_click;
		logic [IVL_W-1:0] gap_ticks;
		logic [CNT_W-1:0] clicks_pending;
	} bsdc_result_t;

endpackage

// ===== rtl/bsdc_core.sv =====
// Per-tick debounce, click window and interval state with its update logic
`timescale 1ns / 1ps

module bsdc_core #(
	parameter int TICK_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       level,
	input  logic [bsdc_pkg::CFG_W-1:0] debounce_ticks,
	input  logic [bsdc_pkg::CFG_W-1:0] double_click_ticks,
	output bsdc_pkg::bsdc_result_t     res
);

	localparam int W  = TICK_BITS;
	// compare width: room for both a tick counter and a register value
	localparam int CW = ((W > bsdc_pkg::CFG_W) ? W : bsdc_pkg::CFG_W) + 1;
	localparam logic [W-1:0]  TMAX    = {W{1'b1}};
	localparam logic [CW-1:0] TMAX_X  = CW'(TMAX);
	localparam logic [CW-1:0] IVL_MAX = CW'({bsdc_pkg::IVL_W{1'b1}});

	logic                       prev_q;
	logic                       deb_act_q;
	logic [W-1:0]               deb_rem_q;
	logic                       win_act_q;
	logic [W-1:0]               win_rem_q;
	logic [bsdc_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]               tsc_q;

	logic                       prev_d;
	logic                       deb_act_d;
	logic [W-1:0]               deb_rem_d;
	logic                       win_act_d;
	logic [W-1:0]               win_rem_d;
	logic [bsdc_pkg::CNT_W-1:0] cnt_d;
	logic [W-1:0]               tsc_d;

	// zero loads as one, values above the counter range saturate
	function automatic logic [W-1:0] load_len(input logic [bsdc_pkg::CFG_W-1:0] v);
		logic [CW-1:0] vx;
		vx = CW'(v);
		if (v == '0)
			return W'(1);
		else if (vx > TMAX_X)
			return TMAX;
		else
			return vx[W-1:0];
	endfunction

	always_comb begin
		logic [W-1:0]  tsc_inc;
		logic [W-1:0]  win_dec;
		logic [W-1:0]  deb_dec;
		logic          win_exp;
		logic          deb_exp;
		logic          click;
		logic [CW-1:0] tsc_x;
		logic [bsdc_pkg::CNT_W-1:0] cnt_a;

		res = '0;

		tsc_inc = (tsc_q != TMAX) ? tsc_q + W'(1) : tsc_q;
		tsc_x   = CW'(tsc_inc);
		tsc_d   = tsc_inc;

		// window runs out before any click of this tick
		win_dec   = (win_rem_q != '0) ? win_rem_q - W'(1) : win_rem_q;
		win_exp   = win_act_q && (win_dec == '0);
		win_rem_d = win_act_q ? win_dec : win_rem_q;
		win_act_d = win_act_q && !win_exp;
		cnt_a     = win_exp ? bsdc_pkg::CNT_ZERO : cnt_q;
		res.single_click = win_exp && (cnt_q == bsdc_pkg::CNT_ONE);

		deb_dec   = (deb_rem_q != '0) ? deb_rem_q - W'(1) : deb_rem_q;
		deb_exp   = deb_act_q && (deb_dec == '0);
		deb_rem_d = deb_act_q ? deb_dec : deb_rem_q;
		deb_act_d = deb_act_q && !deb_exp;

		click = deb_exp && !level && (tsc_x > CW'(debounce_ticks));
		cnt_d = cnt_a;
		if (click) begin
			cnt_d = (cnt_a == bsdc_pkg::CNT_TWO) ? cnt_a : cnt_a + bsdc_pkg::CNT_ONE;
			if (cnt_d == bsdc_pkg::CNT_ONE) begin
				win_act_d = 1'b1;
				win_rem_d = load_len(double_click_ticks);
			end else if (tsc_x < CW'(double_click_ticks)) begin
				res.double_click = 1'b1;
				res.gap_ticks    = (tsc_x > IVL_MAX) ? '1 : tsc_x[bsdc_pkg::IVL_W-1:0];
				cnt_d            = bsdc_pkg::CNT_ZERO;
				win_act_d        = 1'b0;
				win_rem_d        = '0;
			end
			tsc_d = '0;
		end

		// an edge on the expiry tick starts a fresh countdown
		if ((level != prev_q) && !deb_act_d) begin
			deb_act_d = 1'b1;
			deb_rem_d = load_len(debounce_ticks);
		end
		prev_d = level;

		res.clicks_pending = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 1'b1;
			deb_act_q <= 1'b0;
			deb_rem_q <= '0;
			win_act_q <= 1'b0;
			win_rem_q <= '0;
			cnt_q     <= bsdc_pkg::CNT_ZERO;
			tsc_q     <= TMAX;
		end else if (step) begin
			prev_q    <= prev_d;
			deb_act_q <= deb_act_d;
			deb_rem_q <= deb_rem_d;
			win_act_q <= win_act_d;
			win_rem_q <= win_rem_d;
			cnt_q     <= cnt_d;
			tsc_q     <= tsc_d;
		end
	end

endmodule

// ===== rtl/button_single_double_click_detector_top.sv =====
// Top level of the button debounce and single/double click detector
//
// Each request on the s_axis channel is one time tick carrying the raw
// active-low button level in s_axis_tdata[0]. Every tick gives exactly one
// result on m_axis: single click, double click, the interval between the two
// clicks and the pending click count.
// Registers are written over cfg_wen/cfg_idx/cfg_wdata: index 0 is the
// debounce length, index 1 the double-click window, both in ticks.
// A tick passes through the input register, then through the tick update into
// the output register.
// Throughput is one tick per cycle while the receiver does not stall; the tick
// update is a single pass of counters and compares on the state registers.
// When the receiver stalls, the held result stays on m_axis, one more tick
// is taken into the input register, and s_axis_tready then drops until the
// result is taken.
// Reset clears both registers, sets the configuration to 10000 and 1000000
// ticks, marks the button released and saturates the time since last click.
`timescale 1ns / 1ps

module button_single_double_click_detector_top #(
	parameter int TICK_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,  // [0] pin_level, [7:1] zero
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// [0] single_click, [1] double_click, [25:2] gap_ticks,
	// [27:26] clicks_pending, [31:28] zero
	output logic [31:0]                m_axis_tdata,
	input  logic                       cfg_wen,
	input  logic                       cfg_idx,
	input  logic [bsdc_pkg::CFG_W-1:0] cfg_wdata
);

	logic                       in_valid_s1;
	logic                       level_s1;
	logic                       out_valid_q;
	bsdc_pkg::bsdc_result_t     out_q;
	bsdc_pkg::bsdc_result_t     res;
	logic [bsdc_pkg::CFG_W-1:0] debounce_q;
	logic [bsdc_pkg::CFG_W-1:0] double_q;
	logic                       advance;

	// process the held tick whenever the output register is free or draining
	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bsdc_pkg::DEBOUNCE_RST;
			double_q   <= bsdc_pkg::DOUBLE_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				bsdc_pkg::REG_DEBOUNCE: debounce_q <= cfg_wdata;
				bsdc_pkg::REG_DOUBLE:   double_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			level_s1 <= s_axis_tdata[0];
	end

	bsdc_core #(
		.TICK_BITS(TICK_BITS)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (advance),
		.level             (level_s1),
		.debounce_ticks    (debounce_q),
		.double_click_ticks(double_q),
		.res               (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_q.clicks_pending, out_q.gap_ticks,
		out_q.double_click, out_q.single_click};

endmodule

// ===== rtl/bsdc_checker.sv =====
// Port-level checker for the click detector, bound to the top level
`timescale 1ns / 1ps
`include "button_single_double_click_detector_top_assert.svh"

module bsdc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// hold a stalled result
	`BSDC_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped while stalled")
	// a window expiry and a detected double click never share a tick
	`BSDC_ASSERT(a_one_kind, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]), "single and double click together")
	// a double click clears the pending count
	`BSDC_ASSERT(a_dbl_clear, (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[27:26] == 2'd0), "count not cleared on double click")
	// interval only accompanies a double click
	`BSDC_ASSERT(a_ivl_zero, (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[25:2] == 24'd0), "interval without double click")
	// pending count never exceeds two
	`BSDC_ASSERT(a_cnt_range, m_axis_tvalid |-> (m_axis_tdata[27:26] != 2'd3), "pending count out of range")

endmodule

bind button_single_double_click_detector_top bsdc_checker u_bsdc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
